// ===== design/bco_pkg.sv =====
package bco_pkg;

   localparam int unsigned COORD_W   = 32;
   localparam int unsigned SIZE_W    = 31;
   localparam int unsigned SQ_W      = 62;
   localparam int unsigned WIDE_W    = 64;
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 31;

   // Stage numbering of the back pipeline.
   localparam int unsigned ST_LOAD   = 0;
   localparam int unsigned ST_SQUARE = 1;
   localparam int unsigned ST_SUM    = 2;
   localparam int unsigned ST_SQRT0  = 3;
   localparam int unsigned ST_GAP    = ST_SQRT0 + SQRT_STEPS;
   localparam int unsigned ST_MUL    = ST_GAP + 1;
   localparam int unsigned ST_DIV0   = ST_MUL + 1;
   localparam int unsigned NUM_STAGES = ST_DIV0 + DIV_STEPS;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [SIZE_W-1:0] mag_x;
      logic [SIZE_W-1:0] mag_y;
      logic              neg_x;
      logic              neg_y;
      logic [SIZE_W-1:0] radius;
      logic              near;
   } class_type;

   // Working state carried down the back pipeline.
   typedef struct packed {
      logic [SIZE_W-1:0] mag_x;
      logic [SIZE_W-1:0] mag_y;
      logic              neg_x;
      logic              neg_y;
      logic [SIZE_W-1:0] radius;
      logic              near;
      logic              hit;
      logic              zero;
      logic [SQ_W-1:0]   sq_x;
      logic [SQ_W-1:0]   sq_y;
      logic [SQ_W-1:0]   sq_r;
      logic [WIDE_W-1:0] value;
      logic [WIDE_W-1:0] root;
      logic [SIZE_W-1:0] gap;
      logic [SIZE_W-1:0] divisor;
      logic [WIDE_W-1:0] rem_x;
      logic [WIDE_W-1:0] rem_y;
      logic [SIZE_W-1:0] quo_x;
      logic [SIZE_W-1:0] quo_y;
   } lane_type;

   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] push_x;
      logic [COORD_W-1:0] push_y;
   } result_type;

endpackage

// ===== design/box_circle_overlap.sv =====
// Throughput: one item per cycle while the result queue has room; the back pipeline
// of 68 stages gives one root bit or one quotient bit in each root or divider
// stage, and moves whenever its result queue has room.
// Reset: synchronous and active high; it empties both queues and every stage, so
// full and empty read low and high respectively in the cycle after reset.
module box_circle_overlap #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [bco_pkg::COORD_W-1:0]  req_circle_x,
   input  logic signed [bco_pkg::COORD_W-1:0]  req_circle_y,
   input  logic [bco_pkg::SIZE_W-1:0]          req_circle_radius,
   input  logic signed [bco_pkg::COORD_W-1:0]  req_box_x,
   input  logic signed [bco_pkg::COORD_W-1:0]  req_box_y,
   input  logic [bco_pkg::SIZE_W-1:0]          req_box_width,
   input  logic [bco_pkg::SIZE_W-1:0]          req_box_height,
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_hit,
   output logic signed [bco_pkg::COORD_W-1:0]  rsp_push_x,
   output logic signed [bco_pkg::COORD_W-1:0]  rsp_push_y
);

   // The front clamps the circle centre to the box edges and flags items
   // whose offset is within the radius on both axes.
   logic               mid_write, mid_full, mid_read, mid_empty;
   bco_pkg::class_type mid_wdata, mid_rdata;

   // The back squares, takes the root, scales the offset and writes the
   // result into a small output queue that decouples it from the consumer.
   logic                out_write, out_full;
   bco_pkg::result_type out_wdata, out_rdata;

   bco_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_push       (push),
      .in_full       (full),
      .circle_x      (req_circle_x),
      .circle_y      (req_circle_y),
      .circle_radius (req_circle_radius),
      .box_x         (req_box_x),
      .box_y         (req_box_y),
      .box_width     (req_box_width),
      .box_height    (req_box_height),
      .q_write       (mid_write),
      .q_data        (mid_wdata),
      .q_full        (mid_full)
   );

   bco_queue #(
      .WIDTH ($bits(bco_pkg::class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_write),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_read),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   bco_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mid_empty),
      .q_data    (mid_rdata),
      .q_read    (mid_read),
      .out_write (out_write),
      .out_data  (out_wdata),
      .out_full  (out_full)
   );

   // Two entries suffice for a steady transfer every cycle, since the back
   // stalls only while this queue is full.
   bco_queue #(
      .WIDTH ($bits(bco_pkg::result_type)),
      .DEPTH (2)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_write),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rdata),
      .empty     (empty)
   );

   assign rsp_hit    = out_rdata.hit;
   assign rsp_push_x = out_rdata.push_x;
   assign rsp_push_y = out_rdata.push_y;

   // A miss never carries a penetration vector.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> (rsp_push_x == '0 && rsp_push_y == '0))
      else $error("miss result carries a non-zero vector");

   // Nothing can be waiting straight after reset.
   assert property (@(posedge clock) $past(reset) |-> (empty && !full))
      else $error("queues not empty after reset");

   // The input side only fills up after a transfer was offered.
   assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full raised without an input transfer");

endmodule

// ===== design/bco_queue.sv =====
module bco_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/bco_front.sv =====
module bco_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_push,
   output logic                                in_full,
   input  logic signed [bco_pkg::COORD_W-1:0]  circle_x,
   input  logic signed [bco_pkg::COORD_W-1:0]  circle_y,
   input  logic [bco_pkg::SIZE_W-1:0]          circle_radius,
   input  logic signed [bco_pkg::COORD_W-1:0]  box_x,
   input  logic signed [bco_pkg::COORD_W-1:0]  box_y,
   input  logic [bco_pkg::SIZE_W-1:0]          box_width,
   input  logic [bco_pkg::SIZE_W-1:0]          box_height,
   output logic                                q_write,
   output bco_pkg::class_type                  q_data,
   input  logic                                q_full
);

   localparam int unsigned EXT_W = bco_pkg::COORD_W + 2;
   localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(2147483647);
   // Most negative 32-bit value, sign-extended to the working width.
   localparam logic signed [EXT_W-1:0] SAT_MIN =
      {{(EXT_W-bco_pkg::COORD_W+1){1'b1}}, {(bco_pkg::COORD_W-1){1'b0}}};

   logic                               valid_ff, valid_in;
   logic signed [bco_pkg::COORD_W-1:0] cx_ff, cy_ff, bx_ff, by_ff;
   logic [bco_pkg::SIZE_W-1:0]         r_ff, w_ff, h_ff;
   logic                               accept;
   logic signed [EXT_W-1:0]            dx, dy;
   logic [EXT_W-1:0]                   ax, ay;

   function automatic logic signed [EXT_W-1:0] sat(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] res;
      res = v;
      if (v > SAT_MAX) begin
         res = SAT_MAX;
      end else if (v < SAT_MIN) begin
         res = SAT_MIN;
      end
      return res;
   endfunction

   function automatic logic signed [EXT_W-1:0] offset(
      input logic signed [bco_pkg::COORD_W-1:0] c,
      input logic signed [bco_pkg::COORD_W-1:0] centre,
      input logic [bco_pkg::SIZE_W-1:0]         size
   );
      logic signed [EXT_W-1:0] half, lo, hi, ce, res;
      half = signed'(EXT_W'(size >> 1));
      ce   = EXT_W'(c);
      lo   = sat(EXT_W'(centre) - half);
      hi   = sat(EXT_W'(centre) + half);
      res  = '0;
      if (ce < lo) begin
         res = ce - lo;
      end else if (ce > hi) begin
         res = ce - hi;
      end
      return res;
   endfunction

   assign in_full = valid_ff && q_full;
   assign accept  = in_push && !in_full;
   assign q_write = valid_ff && !q_full;

   assign dx = offset(cx_ff, bx_ff, w_ff);
   assign dy = offset(cy_ff, by_ff, h_ff);
   assign ax = dx[EXT_W-1] ? EXT_W'(-dx) : EXT_W'(dx);
   assign ay = dy[EXT_W-1] ? EXT_W'(-dy) : EXT_W'(dy);

   always_comb begin
      q_data.mag_x  = ax[bco_pkg::SIZE_W-1:0];
      q_data.mag_y  = ay[bco_pkg::SIZE_W-1:0];
      q_data.neg_x  = dx[EXT_W-1];
      q_data.neg_y  = dy[EXT_W-1];
      q_data.radius = r_ff;
      q_data.near   = (ax <= EXT_W'(r_ff)) && (ay <= EXT_W'(r_ff));
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_write) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff <= circle_x;
         cy_ff <= circle_y;
         r_ff  <= circle_radius;
         bx_ff <= box_x;
         by_ff <= box_y;
         w_ff  <= box_width;
         h_ff  <= box_height;
      end
   end

endmodule

// ===== design/bco_back.sv =====
module bco_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  bco_pkg::class_type      q_data,
   output logic                    q_read,
   output logic                    out_write,
   output bco_pkg::result_type     out_data,
   input  logic                    out_full
);

   localparam int unsigned NS = bco_pkg::NUM_STAGES;

   bco_pkg::lane_type st_ff [NS];
   bco_pkg::lane_type st_in [NS];
   logic [NS-1:0]     valid_ff;
   logic              advance;
   bco_pkg::lane_type last;
   logic [bco_pkg::COORD_W-1:0] mag_x, mag_y;

   // The whole pipeline moves together; it holds only when its last stage
   // cannot hand a result on.
   assign advance   = !(valid_ff[NS-1] && out_full);
   assign q_read    = advance && !q_empty;
   assign out_write = advance && valid_ff[NS-1];

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            st_in[k]        = '0;
            st_in[k].mag_x  = q_data.mag_x;
            st_in[k].mag_y  = q_data.mag_y;
            st_in[k].neg_x  = q_data.neg_x;
            st_in[k].neg_y  = q_data.neg_y;
            st_in[k].radius = q_data.radius;
            st_in[k].near   = q_data.near;
         end else begin
            st_in[k] = st_ff[k-1];
            if (k == bco_pkg::ST_SQUARE) begin
               st_in[k].sq_x = st_ff[k-1].mag_x * st_ff[k-1].mag_x;
               st_in[k].sq_y = st_ff[k-1].mag_y * st_ff[k-1].mag_y;
               st_in[k].sq_r = st_ff[k-1].radius * st_ff[k-1].radius;
            end else if (k == bco_pkg::ST_SUM) begin
               st_in[k].value = bco_pkg::WIDE_W'(st_ff[k-1].sq_x)
                              + bco_pkg::WIDE_W'(st_ff[k-1].sq_y);
               st_in[k].hit   = st_ff[k-1].near
                              && (bco_pkg::WIDE_W'(st_ff[k-1].sq_x)
                                  + bco_pkg::WIDE_W'(st_ff[k-1].sq_y)
                                  <= bco_pkg::WIDE_W'(st_ff[k-1].sq_r));
               st_in[k].zero  = (st_ff[k-1].sq_x == '0) && (st_ff[k-1].sq_y == '0);
               st_in[k].root  = '0;
            end else if (k >= bco_pkg::ST_SQRT0 && k < bco_pkg::ST_GAP) begin
               // One result bit of the integer root per stage.
               if (st_ff[k-1].value >= st_ff[k-1].root
                   + (64'd1 << (62 - 2 * (k - bco_pkg::ST_SQRT0)))) begin
                  st_in[k].value = st_ff[k-1].value - st_ff[k-1].root
                                 - (64'd1 << (62 - 2 * (k - bco_pkg::ST_SQRT0)));
                  st_in[k].root  = (st_ff[k-1].root >> 1)
                                 + (64'd1 << (62 - 2 * (k - bco_pkg::ST_SQRT0)));
               end else begin
                  st_in[k].root  = st_ff[k-1].root >> 1;
               end
            end else if (k == bco_pkg::ST_GAP) begin
               st_in[k].gap     = st_ff[k-1].radius - st_ff[k-1].root[bco_pkg::SIZE_W-1:0];
               st_in[k].divisor = st_ff[k-1].zero ? bco_pkg::SIZE_W'(1)
                                : st_ff[k-1].root[bco_pkg::SIZE_W-1:0];
            end else if (k == bco_pkg::ST_MUL) begin
               st_in[k].rem_x = bco_pkg::WIDE_W'(st_ff[k-1].mag_x)
                              * bco_pkg::WIDE_W'(st_ff[k-1].gap);
               st_in[k].rem_y = bco_pkg::WIDE_W'(st_ff[k-1].mag_y)
                              * bco_pkg::WIDE_W'(st_ff[k-1].gap);
               st_in[k].quo_x = '0;
               st_in[k].quo_y = '0;
            end else begin
               // One quotient bit per stage, most significant first.
               if (st_ff[k-1].rem_x >= (bco_pkg::WIDE_W'(st_ff[k-1].divisor)
                                        << (bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0))))
               begin
                  st_in[k].rem_x = st_ff[k-1].rem_x - (bco_pkg::WIDE_W'(st_ff[k-1].divisor)
                                 << (bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0)));
                  st_in[k].quo_x[bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0)] = 1'b1;
               end
               if (st_ff[k-1].rem_y >= (bco_pkg::WIDE_W'(st_ff[k-1].divisor)
                                        << (bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0))))
               begin
                  st_in[k].rem_y = st_ff[k-1].rem_y - (bco_pkg::WIDE_W'(st_ff[k-1].divisor)
                                 << (bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0)));
                  st_in[k].quo_y[bco_pkg::DIV_STEPS - 1 - (k - bco_pkg::ST_DIV0)] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], q_read};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign last  = st_ff[NS-1];
   assign mag_x = bco_pkg::COORD_W'(last.quo_x);
   assign mag_y = bco_pkg::COORD_W'(last.quo_y);

   always_comb begin
      out_data.hit    = last.hit;
      out_data.push_x = '0;
      out_data.push_y = '0;
      if (last.hit) begin
         if (last.zero) begin
            out_data.push_x = bco_pkg::COORD_W'(last.radius);
         end else begin
            out_data.push_x = last.neg_x ? -mag_x : mag_x;
            out_data.push_y = last.neg_y ? -mag_y : mag_y;
         end
      end
   end

endmodule
